// File: rtl/fqs_pkg.sv
// Shared types, codes and defaults for the searchable FIFO queue.
`default_nettype none

package fqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // request codes
    localparam logic [2:0] OP_PUSH     = 3'd0;
    localparam logic [2:0] OP_POP      = 3'd1;
    localparam logic [2:0] OP_CONTAINS = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_INDEX = 2'd2;
    localparam logic [1:0] ERR_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
        logic [3:0]  index;
    } fqs_in_t;

    typedef struct packed {
        logic [31:0] data;
        logic        found;
        logic [1:0]  error;
        logic [4:0]  count;
    } fqs_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RDWAIT,
        ST_SCAN,
        ST_OUT
    } fqs_state_t;

    // read address source
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_INDEX,
        RD_SCAN
    } fqs_rd_src_t;

    typedef struct packed {
        logic        load_req;
        logic        do_push;
        logic        do_pop;
        logic        do_clear;
        logic        rd_en;
        fqs_rd_src_t rd_src;
        logic        scan_start;
        logic        scan_step;
        logic        res_init;
        logic [1:0]  res_err;
        logic        res_take_data;
        logic        res_set_found;
        logic        out_load;
    } fqs_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       index_oob;
        logic       match;
        logic       scan_last;
        logic       out_free;
    } fqs_status_t;

endpackage

`default_nettype wire

// File: rtl/fqs_ctrl.sv
// Controller state machine for the searchable FIFO queue.
`default_nettype none

module fqs_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  fqs_pkg::fqs_status_t st,
    output fqs_pkg::fqs_cmd_t    cmd
);
    import fqs_pkg::*;

    fqs_state_t state_reg;
    fqs_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                state_next = ST_OUT;
                unique case (st.op)
                    OP_POP: begin
                        if (!st.empty) state_next = ST_RDWAIT;
                    end
                    OP_READ: begin
                        if (!st.index_oob) state_next = ST_RDWAIT;
                    end
                    OP_CONTAINS: begin
                        if (!st.empty) state_next = ST_SCAN;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_RDWAIT: begin
                state_next = ST_OUT;
            end
            ST_SCAN: begin
                if (st.match || st.scan_last) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (st.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        cmd.rd_src  = RD_HEAD;
        cmd.res_err = ERR_OK;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            ST_DECODE: begin
                cmd.res_init = 1'b1;
                unique case (st.op)
                    OP_PUSH: begin
                        if (st.full) cmd.res_err = ERR_FULL;
                        else         cmd.do_push = 1'b1;
                    end
                    OP_POP: begin
                        if (st.empty) begin
                            cmd.res_err = ERR_EMPTY;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = RD_HEAD;
                        end
                    end
                    OP_CONTAINS: begin
                        if (!st.empty) begin
                            cmd.rd_en      = 1'b1;
                            cmd.rd_src     = RD_HEAD;
                            cmd.scan_start = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (st.index_oob) begin
                            cmd.res_err = ERR_INDEX;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = RD_INDEX;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.do_clear = 1'b1;
                    end
                    default: cmd.res_init = 1'b1;
                endcase
            end
            ST_RDWAIT: begin
                cmd.res_take_data = 1'b1;
                cmd.do_pop        = (st.op == OP_POP);
            end
            ST_SCAN: begin
                if (st.match) begin
                    cmd.res_set_found = 1'b1;
                end else if (!st.scan_last) begin
                    cmd.scan_step = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_src    = RD_SCAN;
                end
            end
            ST_OUT: begin
                cmd.out_load = st.out_free;
            end
            default: s_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/fqs_datapath.sv
// Datapath: ring storage, pointers, scan counter, result staging and output register.
`default_nettype none

module fqs_datapath #(
    parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  fqs_pkg::fqs_in_t     s_data,
    input  fqs_pkg::fqs_cmd_t    cmd,
    output fqs_pkg::fqs_status_t st,
    output logic                 m_valid,
    input  wire                  m_ready,
    output fqs_pkg::fqs_out_t    m_data
);
    import fqs_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > 4) ? FILL_W : 4;
    localparam logic [PTR_W:0]    DEPTH_S = (PTR_W + 1)'(DEPTH);
    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(DEPTH);

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                   input logic [PTR_W:0]   k);
        logic [PTR_W:0] s;
        s = {1'b0, p} + k;
        if (s >= DEPTH_S) s = s - DEPTH_S;
        return s[PTR_W-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [PTR_W-1:0]      rd_addr;

    fqs_in_t               req_reg;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [PTR_W-1:0]      scan_k_reg;
    logic [DATA_WIDTH-1:0] res_data_reg;
    logic                  res_found_reg;
    logic [1:0]            res_err_reg;
    logic                  m_valid_reg;
    fqs_out_t              m_data_reg;
    logic [DATA_WIDTH-1:0] word;

    assign word = DATA_WIDTH'(req_reg.value);

    // status back to the controller
    always_comb begin
        st.op        = req_reg.op;
        st.full      = (fill_reg == DEPTH_F);
        st.empty     = (fill_reg == '0);
        st.index_oob = (CMP_W'(req_reg.index) >= CMP_W'(fill_reg));
        st.match     = (rd_data_reg == word);
        st.scan_last = ((FILL_W'(scan_k_reg) + FILL_W'(1)) >= fill_reg);
        st.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        unique case (cmd.rd_src)
            RD_HEAD:  rd_addr = head_reg;
            RD_INDEX: rd_addr = ring_add(head_reg, (PTR_W + 1)'(req_reg.index));
            default:  rd_addr = ring_add(head_reg, {1'b0, scan_k_reg} + (PTR_W + 1)'(1));
        endcase
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (cmd.do_clear) begin
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end else if (cmd.do_push) begin
            tail_next = ring_add(tail_reg, (PTR_W + 1)'(1));
            fill_next = fill_reg + FILL_W'(1);
        end else if (cmd.do_pop) begin
            head_next = ring_add(head_reg, (PTR_W + 1)'(1));
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    // ring storage, registered read port
    always_ff @(posedge aclk) begin
        if (cmd.do_push) mem[tail_reg] <= word;
        if (cmd.rd_en)   rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            if (cmd.out_load)  m_valid_reg <= 1'b1;
            else if (m_ready)  m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) req_reg <= s_data;
        if (cmd.scan_start)     scan_k_reg <= '0;
        else if (cmd.scan_step) scan_k_reg <= scan_k_reg + PTR_W'(1);
        if (cmd.res_init) begin
            res_data_reg  <= '0;
            res_found_reg <= 1'b0;
            res_err_reg   <= cmd.res_err;
        end else begin
            if (cmd.res_take_data) res_data_reg  <= rd_data_reg;
            if (cmd.res_set_found) res_found_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            m_data_reg.data  <= 32'(res_data_reg);
            m_data_reg.found <= res_found_reg;
            m_data_reg.error <= res_err_reg;
            m_data_reg.count <= 5'(fill_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_F)
        else $error("fill above depth");

    a_ring_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg == ring_add(head_reg, (PTR_W + 1)'(fill_reg)))
        else $error("tail, head and fill disagree");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_push |-> !st.full)
        else $error("write into full ring");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_pop |-> !st.empty)
        else $error("pop from empty ring");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(m_data_reg) && m_valid_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: rtl/fifo_queue_with_search_top.sv
// Top level of the FIFO queue with push, pop, search, indexed read and clear.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  s_      | in        | s_valid / s_ready  | s_data  (op, value, index)
//  m_      | out       | m_valid / m_ready  | m_data  (data, found, error, count)
//
// One request at a time. Push, clear, unused codes and rejected requests pass from
// the transfer through DECODE and OUT back to IDLE; pop and read at index add RDWAIT
// (one registered memory read). Contains on a non-empty queue adds SCAN: entries are
// compared one per cycle through the single read port, at most DEPTH of them.
// Reset clears pointers and fill; storage is not cleared.
// A result waiting in the output register does not block the next transfer;
// only the hand-off of the following result waits for m_ready.
`default_nettype none

module fifo_queue_with_search_top #(
    parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  fqs_pkg::fqs_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output fqs_pkg::fqs_out_t m_data
);
    import fqs_pkg::*;

    fqs_cmd_t    cmd;
    fqs_status_t st;

    fqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    fqs_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
